@@ rtl/core/handle_table_find_or_allocate_top_assert.svh @@
// Assertion macros for the handle table.
// Each macro takes a label, an antecedent and a consequent.
`ifndef HANDLE_TABLE_FIND_OR_ALLOCATE_TOP_ASSERT_SVH
`define HANDLE_TABLE_FIND_OR_ALLOCATE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle
`define HTFA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// Consequent must hold in the following cycle
`define HTFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define HTFA_ASSERT_SAME(lbl, ante, cons)
`define HTFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/htfa_pkg.sv @@
package htfa_pkg;

    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 8;
    localparam int HANDLE_W = 16;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DROP  = 3'd4;

    // Status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // Slots below this one are the console slots
    localparam logic [SLOT_W-1:0] FIRST_USER_SLOT = 8'd3;

    // Outcome of an open scan
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] hit;
        logic              have_free;
        logic [SLOT_W-1:0] free_slot;
    } scan_res_t;

endpackage

@@ rtl/core/htfa_mem.sv @@
module htfa_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [htfa_pkg::HANDLE_W-1:0] wdata,
    input  logic                          re,
    input  logic [ADDR_W-1:0]             raddr,
    output logic [htfa_pkg::HANDLE_W-1:0] rdata
);

    logic [htfa_pkg::HANDLE_W-1:0] mem_reg [DEPTH];
    logic [htfa_pkg::HANDLE_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/htfa_scan.sv @@
module htfa_scan #(
    parameter int IDX_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          vld,
    input  logic [IDX_W-1:0]              idx,
    input  logic                          occ,
    input  logic [htfa_pkg::HANDLE_W-1:0] data,
    input  logic [htfa_pkg::HANDLE_W-1:0] host,
    output htfa_pkg::scan_res_t           res
);

    logic                        found_reg, found_next;
    logic [htfa_pkg::SLOT_W-1:0] hit_reg, hit_next;
    logic                        free_vld_reg, free_vld_next;
    logic [htfa_pkg::SLOT_W-1:0] free_reg, free_next;

    // First matching occupied slot, last free slot
    always_comb
    begin
        found_next    = found_reg;
        hit_next      = hit_reg;
        free_vld_next = free_vld_reg;
        free_next     = free_reg;
        if (clear)
        begin
            found_next    = 1'b0;
            free_vld_next = 1'b0;
        end
        else if (vld)
        begin
            if (occ)
            begin
                if (!found_reg && data == host)
                begin
                    found_next = 1'b1;
                    hit_next   = htfa_pkg::SLOT_W'(idx);
                end
            end
            else
            begin
                free_vld_next = 1'b1;
                free_next     = htfa_pkg::SLOT_W'(idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            free_vld_reg <= 1'b0;
        end
        else
        begin
            found_reg    <= found_next;
            free_vld_reg <= free_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        free_reg <= free_next;
    end

    assign res.found     = found_reg;
    assign res.hit       = hit_reg;
    assign res.have_free = free_vld_reg;
    assign res.free_slot = free_reg;

endmodule

@@ rtl/core/handle_table_find_or_allocate_top.sv @@
// Handle table: local slot to host handle map, find-or-allocate on open.
// Open: one RAM read per slot over slots 3 to TABLE_SLOTS-1, then a drain state,
//   then a finish state that registers the result.
// Close, query, add/drop user: the latched request goes straight to the finish state.
// One item in flight at a time; result backpressure holds the finish state.
// Reset: console slots 0-2 marked occupied, user count zero; handle RAM not cleared.
`include "handle_table_find_or_allocate_top_assert.svh"

module handle_table_find_or_allocate_top #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [htfa_pkg::MODE_W-1:0]   mode,
    input  logic [htfa_pkg::SLOT_W-1:0]   slot,
    input  logic [htfa_pkg::HANDLE_W-1:0] host_handle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [htfa_pkg::SLOT_W-1:0]   slot_out,
    output logic [htfa_pkg::HANDLE_W-1:0] handle_out,
    output logic                          is_open,
    output logic                          release_all
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = htfa_pkg::HANDLE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              cnt_reg, cnt_next;
    logic [TABLE_SLOTS-1:0]        occ_reg, occ_next;
    logic                          occ_rd_reg;
    logic                          pipe_vld_reg;
    logic [IDX_W-1:0]              pipe_idx_reg;
    logic [CNT_W-1:0]              users_reg, users_next;

    // Latched request
    logic [htfa_pkg::MODE_W-1:0]   mode_reg;
    logic [htfa_pkg::SLOT_W-1:0]   slot_reg;
    logic [htfa_pkg::HANDLE_W-1:0] host_reg;
    logic                          range_reg;

    // Output register
    logic                          out_vld_reg, out_vld_next;
    logic                          status_reg;
    logic [htfa_pkg::SLOT_W-1:0]   slot_out_reg;
    logic [htfa_pkg::HANDLE_W-1:0] handle_out_reg;
    logic                          is_open_reg;
    logic                          release_reg;

    logic                          accept;
    logic                          in_range;
    logic [IDX_W-1:0]              in_idx;
    logic [IDX_W-1:0]              occ_addr;
    logic                          mem_re;
    logic [IDX_W-1:0]              mem_raddr;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [htfa_pkg::HANDLE_W-1:0] mem_q;
    logic                          load;
    htfa_pkg::scan_res_t           scan_res;

    // Result of the finishing cycle
    logic                          r_status;
    logic [htfa_pkg::SLOT_W-1:0]   r_slot;
    logic [htfa_pkg::HANDLE_W-1:0] r_handle;
    logic                          r_open;
    logic                          r_release;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = ({1'b0, slot} < (htfa_pkg::SLOT_W + 1)'(TABLE_SLOTS));
    assign in_idx   = slot[IDX_W-1:0];
    assign load     = (state_reg == S_FIN) && (!out_vld_reg || out_ready);

    // Single read port into occupancy and handle RAM: scan counter or request slot
    assign occ_addr  = (state_reg == S_SCAN) ? cnt_reg : in_idx;
    assign mem_raddr = occ_addr;
    assign mem_re    = (state_reg == S_SCAN) ||
                       (accept && mode == htfa_pkg::MODE_QUERY && in_range);

    htfa_mem #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (host_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    htfa_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .vld   (pipe_vld_reg),
        .idx   (pipe_idx_reg),
        .occ   (occ_rd_reg),
        .data  (mem_q),
        .host  (host_reg),
        .res   (scan_res)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == htfa_pkg::MODE_OPEN)
                    begin
                        state_next = S_SCAN;
                        cnt_next   = IDX_W'(htfa_pkg::FIRST_USER_SLOT);
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result and state update
    always_comb
    begin
        r_status   = htfa_pkg::ST_ERR;
        r_slot     = slot_reg;
        r_handle   = '0;
        r_open     = 1'b0;
        r_release  = 1'b0;
        occ_next   = occ_reg;
        users_next = users_reg;
        mem_we     = 1'b0;
        mem_waddr  = scan_res.free_slot[IDX_W-1:0];
        case (mode_reg)
            htfa_pkg::MODE_OPEN:
            begin
                if (scan_res.found)
                begin
                    r_status = htfa_pkg::ST_OK;
                    r_slot   = scan_res.hit;
                    r_handle = host_reg;
                end
                else if (scan_res.have_free)
                begin
                    r_status = htfa_pkg::ST_OK;
                    r_slot   = scan_res.free_slot;
                    r_handle = host_reg;
                    mem_we   = load;
                    if (load)
                    begin
                        occ_next[mem_waddr] = 1'b1;
                    end
                end
            end
            htfa_pkg::MODE_CLOSE:
            begin
                if (range_reg)
                begin
                    r_status = htfa_pkg::ST_OK;
                    if (load)
                    begin
                        occ_next[slot_reg[IDX_W-1:0]] = 1'b0;
                    end
                end
            end
            htfa_pkg::MODE_QUERY:
            begin
                if (range_reg && occ_rd_reg)
                begin
                    r_status = htfa_pkg::ST_OK;
                    r_open   = 1'b1;
                    // Console slots hold their preset handle
                    r_handle = (slot_reg < htfa_pkg::FIRST_USER_SLOT) ?
                               htfa_pkg::HANDLE_W'(slot_reg) : mem_q;
                end
            end
            htfa_pkg::MODE_ADD:
            begin
                r_status = htfa_pkg::ST_OK;
                if (load && users_reg != '1)
                begin
                    users_next = users_reg + 1'b1;
                end
            end
            htfa_pkg::MODE_DROP:
            begin
                r_status = htfa_pkg::ST_OK;
                if (users_reg != '0)
                begin
                    r_release = (users_reg == CNT_W'(1));
                    if (load)
                    begin
                        users_next = users_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                r_status = htfa_pkg::ST_ERR;
            end
        endcase
    end

    assign out_vld_next = load ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= TABLE_SLOTS'(3'b111);
            users_reg    <= '0;
            out_vld_reg  <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            users_reg    <= users_next;
            out_vld_reg  <= out_vld_next;
            pipe_vld_reg <= (state_reg == S_SCAN);
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        pipe_idx_reg <= cnt_reg;
        if (state_reg == S_SCAN || accept)
        begin
            occ_rd_reg <= occ_reg[occ_addr] && ((state_reg == S_SCAN) || in_range);
        end
        if (accept)
        begin
            mode_reg  <= mode;
            slot_reg  <= slot;
            host_reg  <= host_handle;
            range_reg <= in_range;
        end
        if (load)
        begin
            status_reg     <= r_status;
            slot_out_reg   <= r_slot;
            handle_out_reg <= r_handle;
            is_open_reg    <= r_open;
            release_reg    <= r_release;
        end
    end

    assign out_valid   = out_vld_reg;
    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign handle_out  = handle_out_reg;
    assign is_open     = is_open_reg;
    assign release_all = release_reg;

    // Checks
    `HTFA_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
    `HTFA_ASSERT_SAME(a_load_when_free, load, !out_vld_reg || out_ready)
    `HTFA_ASSERT_SAME(a_alloc_user_slot, mem_we, scan_res.free_slot >= htfa_pkg::FIRST_USER_SLOT)
    `HTFA_ASSERT_SAME(a_release_ok, out_vld_reg && release_reg, status_reg == htfa_pkg::ST_OK)

endmodule
